>>> rtl/pat_pkg.sv
// Shared types, constants and a helper function for the pointer acceleration tracker.
`timescale 1ns / 1ps
`default_nettype none
package pat_pkg;

   localparam int POS_W   = 32;
   localparam int SIZE_W  = 13;
   localparam int COORD_W = 13;
   localparam int MOT_W   = 17;
   localparam int MAG_W   = 16;
   localparam int K_W     = 12;
   localparam int PROD_W  = 28;
   localparam int CNT_W   = 5;
   localparam int SPEED_W = 8;
   localparam int BTN_W   = 16;

   localparam int RECIP_STEPS = POS_W;
   localparam int MUL_STEPS   = K_W;
   localparam int QUO_STEPS   = COORD_W;

   localparam logic [1:0] EV_MOVE = 2'd0;
   localparam logic [1:0] EV_DOWN = 2'd1;
   localparam logic [1:0] EV_UP   = 2'd2;

   localparam logic [1:0] BTN_NONE = 2'd0;
   localparam logic [1:0] BTN_ONE  = 2'd1;
   localparam logic [1:0] BTN_TWO  = 2'd2;
   localparam logic [1:0] BTN_THREE = 2'd3;

   localparam logic [1:0] REG_SPEED  = 2'd0;
   localparam logic [1:0] REG_WIDTH  = 2'd1;
   localparam logic [1:0] REG_HEIGHT = 2'd2;

   localparam logic [2:0] NIBBLE_LEN [16] = '{
      3'd0, 3'd1, 3'd2, 3'd2, 3'd3, 3'd3, 3'd3, 3'd3,
      3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4
   };

   typedef struct packed {
      logic recip_start;
      logic item_start;
   } axis_ctl_type;

   typedef enum logic [5:0] {
      AX_IDLE  = 6'b000001,
      AX_RECIP = 6'b000010,
      AX_PREP  = 6'b000100,
      AX_MUL   = 6'b001000,
      AX_ACC   = 6'b010000,
      AX_QUO   = 6'b100000
   } axis_state_type;

   typedef enum logic [4:0] {
      TOP_IDLE  = 5'b00001,
      TOP_CALC  = 5'b00010,
      TOP_START = 5'b00100,
      TOP_RUN   = 5'b01000,
      TOP_EMIT  = 5'b10000
   } top_state_type;

   function automatic logic [4:0] bit_len16(input logic [MAG_W-1:0] v);
      logic [4:0]       r;
      logic [MAG_W-1:0] t;
      r = 5'd0;
      t = v;
      if (|t[15:8]) begin
         r = 5'd8;
         t = t >> 8;
      end
      if (|t[7:4]) begin
         r = r + 5'd4;
         t = t >> 4;
      end
      return r + {2'b00, NIBBLE_LEN[t[3:0]]};
   endfunction

endpackage
`default_nettype wire

>>> rtl/pat_axis.sv
// One axis: reciprocal of the screen size, serial acceleration, saturating position, scaling.
`timescale 1ns / 1ps
`default_nettype none
module pat_axis (
   input  logic                              clock,
   input  logic                              reset,
   input  pat_pkg::axis_ctl_type             ctl,
   input  logic [pat_pkg::SIZE_W-1:0]        size,
   input  logic [pat_pkg::SPEED_W-1:0]       speed,
   input  logic signed [pat_pkg::MOT_W-1:0]  motion,
   output logic                              busy,
   output logic [pat_pkg::COORD_W-1:0]       coord
);
   import pat_pkg::*;

   axis_state_type     state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [POS_W-1:0]   recip_ff, recip_in;
   logic [SIZE_W-1:0]  den_ff, den_in;
   logic [SIZE_W-1:0]  rrem_ff, rrem_in;
   logic [MAG_W-1:0]   mag_ff, mag_in;
   logic               neg_ff, neg_in;
   logic [K_W-1:0]     k_ff, k_in;
   logic [PROD_W-1:0]  msh_ff, msh_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [POS_W-1:0]   qrem_ff, qrem_in;
   logic [COORD_W-1:0] plo_ff, plo_in;
   logic [COORD_W-1:0] quo_ff, quo_in;

   logic [SIZE_W-1:0]  den;
   logic [SIZE_W:0]    rtrial, rdiff;
   logic               rge;
   logic [POS_W:0]     qtrial, qdiff;
   logic               qge;
   logic [MOT_W-1:0]   mabs;
   logic [SIZE_W-1:0]  kfull;
   logic [POS_W-1:0]   prod_ext;
   logic [POS_W:0]     sum;
   logic [POS_W-1:0]   accv;

   always_comb begin
      den      = (size < SIZE_W'(2)) ? SIZE_W'(1) : size - SIZE_W'(1);
      rtrial   = {rrem_ff, 1'b1};
      rge      = rtrial >= {1'b0, den_ff};
      rdiff    = rtrial - {1'b0, den_ff};
      qtrial   = {qrem_ff, plo_ff[COORD_W-1]};
      qge      = qtrial >= {1'b0, recip_ff};
      qdiff    = qtrial - {1'b0, recip_ff};
      mabs     = motion[MOT_W-1] ? (MOT_W'(0) - motion) : motion;
      kfull    = SIZE_W'(bit_len16(mag_ff)) * SIZE_W'(speed);
      prod_ext = {{(POS_W-PROD_W){1'b0}}, prod_ff};
      sum      = {1'b0, pos_ff} + {1'b0, prod_ext};
      if (neg_ff) begin
         accv = (pos_ff < prod_ext) ? '0 : pos_ff - prod_ext;
      end else begin
         accv = sum[POS_W] ? '1 : sum[POS_W-1:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      pos_in   = pos_ff;
      recip_in = recip_ff;
      den_in   = den_ff;
      rrem_in  = rrem_ff;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      k_in     = k_ff;
      msh_in   = msh_ff;
      prod_in  = prod_ff;
      qrem_in  = qrem_ff;
      plo_in   = plo_ff;
      quo_in   = quo_ff;
      case (state_ff)
         AX_IDLE: begin
            if (ctl.recip_start) begin
               den_in   = den;
               rrem_in  = '0;
               recip_in = '0;
               cnt_in   = '0;
               state_in = AX_RECIP;
            end else if (ctl.item_start) begin
               mag_in   = mabs[MAG_W-1:0];
               neg_in   = motion[MOT_W-1];
               state_in = AX_PREP;
            end
         end
         AX_RECIP: begin
            recip_in = {recip_ff[POS_W-2:0], rge};
            rrem_in  = rge ? rdiff[SIZE_W-1:0] : rtrial[SIZE_W-1:0];
            cnt_in   = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(RECIP_STEPS - 1)) begin
               state_in = AX_IDLE;
            end
         end
         AX_PREP: begin
            k_in     = kfull[K_W-1:0];
            msh_in   = {{(PROD_W-MAG_W){1'b0}}, mag_ff};
            prod_in  = '0;
            cnt_in   = '0;
            state_in = AX_MUL;
         end
         AX_MUL: begin
            if (k_ff[0]) begin
               prod_in = prod_ff + msh_ff;
            end
            msh_in = msh_ff << 1;
            k_in   = k_ff >> 1;
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(MUL_STEPS - 1)) begin
               state_in = AX_ACC;
            end
         end
         AX_ACC: begin
            pos_in   = accv;
            qrem_in  = {{COORD_W{1'b0}}, accv[POS_W-1:COORD_W]};
            plo_in   = accv[COORD_W-1:0];
            quo_in   = '0;
            cnt_in   = '0;
            state_in = AX_QUO;
         end
         AX_QUO: begin
            quo_in  = {quo_ff[COORD_W-2:0], qge};
            qrem_in = qge ? qdiff[POS_W-1:0] : qtrial[POS_W-1:0];
            plo_in  = plo_ff << 1;
            cnt_in  = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(QUO_STEPS - 1)) begin
               state_in = AX_IDLE;
            end
         end
         default: begin
            state_in = AX_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= AX_IDLE;
         pos_ff   <= '0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
      end
      cnt_ff   <= cnt_in;
      recip_ff <= recip_in;
      den_ff   <= den_in;
      rrem_ff  <= rrem_in;
      mag_ff   <= mag_in;
      neg_ff   <= neg_in;
      k_ff     <= k_in;
      msh_ff   <= msh_in;
      prod_ff  <= prod_in;
      qrem_ff  <= qrem_in;
      plo_ff   <= plo_in;
      quo_ff   <= quo_in;
   end

   assign busy  = (state_ff != AX_IDLE);
   assign coord = quo_ff;

endmodule
`default_nettype wire

>>> rtl/pointer_accel_tracker.sv
// Top level of the pointer acceleration tracker: register port, sequencing, event output.
// The second result of an item follows in the cycle after the first is taken. A new
// item is accepted only after the previous one has been fully emitted; each item runs
// the 12-step serial multiply and the 13-step serial divide per axis. Reset and every
// screen size write start a 32-step reciprocal per axis, and req_ready stays low until
// it is done. Reset clears positions.
`timescale 1ns / 1ps
`default_nettype none
module pointer_accel_tracker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [15:0]                 req_x_motion,
   input  logic signed [15:0]                 req_y_motion,
   input  logic [pat_pkg::BTN_W-1:0]          req_buttons,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [1:0]                         rsp_event_kind,
   output logic [pat_pkg::COORD_W-1:0]        rsp_screen_x,
   output logic [pat_pkg::COORD_W-1:0]        rsp_screen_y,
   output logic [1:0]                         rsp_button_number,
   output logic                               rsp_last,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [3:0]                         csr_paddr,
   input  logic [31:0]                        csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready
);
   import pat_pkg::*;

   top_state_type      state_ff, state_in;
   logic [SPEED_W-1:0] speed_ff, speed_in;
   logic [SIZE_W-1:0]  width_ff, width_in;
   logic [SIZE_W-1:0]  height_ff, height_in;
   logic               recalc_ff, recalc_in;
   logic [BTN_W-1:0]   prev_ff, prev_in;
   logic [BTN_W-1:0]   old_ff, old_in;
   logic [BTN_W-1:0]   flags_ff, flags_in;
   logic [MOT_W-1:0]   mx_ff, mx_in;
   logic [MOT_W-1:0]   my_ff, my_in;
   logic               valid_ff, valid_in;
   logic [1:0]         kind_ff, kind_in;
   logic [1:0]         bnum_ff, bnum_in;
   logic               last_ff, last_in;
   logic [COORD_W-1:0] sx_ff, sx_in;
   logic [COORD_W-1:0] sy_ff, sy_in;
   logic               pend_ff, pend_in;
   logic [1:0]         bkind_ff, bkind_in;
   logic [1:0]         bsel_ff, bsel_in;

   axis_ctl_type       ctl;
   logic               busy_x, busy_y;
   logic [COORD_W-1:0] coord_x, coord_y;
   logic               csr_wr;
   logic [1:0]         csr_idx;
   logic               up;
   logic [BTN_W-1:0]   diff;
   logic [1:0]         btn;
   logic               has_move;
   logic               has_btn;

   pat_axis u_axis_x (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .size   (width_ff),
      .speed  (speed_ff),
      .motion (mx_ff),
      .busy   (busy_x),
      .coord  (coord_x)
   );

   pat_axis u_axis_y (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .size   (height_ff),
      .speed  (speed_ff),
      .motion (my_ff),
      .busy   (busy_y),
      .coord  (coord_y)
   );

   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_idx    = csr_paddr[3:2];
   assign csr_pready = 1'b1;

   always_comb begin
      case (csr_idx)
         REG_SPEED:  csr_prdata = {{(32-SPEED_W){1'b0}}, speed_ff};
         REG_WIDTH:  csr_prdata = {{(32-SIZE_W){1'b0}}, width_ff};
         REG_HEIGHT: csr_prdata = {{(32-SIZE_W){1'b0}}, height_ff};
         default:    csr_prdata = '0;
      endcase
   end

   assign ctl.recip_start = (state_ff == TOP_IDLE) && recalc_ff;
   assign ctl.item_start  = (state_ff == TOP_START);
   assign req_ready       = (state_ff == TOP_IDLE) && !recalc_ff;

   always_comb begin
      up       = flags_ff > old_ff;
      diff     = up ? flags_ff - old_ff : old_ff - flags_ff;
      case (diff)
         BTN_W'(1): btn = BTN_ONE;
         BTN_W'(2): btn = BTN_TWO;
         BTN_W'(4): btn = BTN_THREE;
         default:   btn = BTN_NONE;
      endcase
      has_btn  = (btn != BTN_NONE);
      has_move = (mx_ff != '0) || (my_ff != '0);
   end

   always_comb begin
      state_in  = state_ff;
      speed_in  = speed_ff;
      width_in  = width_ff;
      height_in = height_ff;
      recalc_in = recalc_ff;
      prev_in   = prev_ff;
      old_in    = old_ff;
      flags_in  = flags_ff;
      mx_in     = mx_ff;
      my_in     = my_ff;
      valid_in  = valid_ff;
      kind_in   = kind_ff;
      bnum_in   = bnum_ff;
      last_in   = last_ff;
      sx_in     = sx_ff;
      sy_in     = sy_ff;
      pend_in   = pend_ff;
      bkind_in  = bkind_ff;
      bsel_in   = bsel_ff;
      case (state_ff)
         TOP_IDLE: begin
            if (recalc_ff) begin
               recalc_in = 1'b0;
               state_in  = TOP_CALC;
            end else if (req_valid) begin
               mx_in    = {req_x_motion[15], req_x_motion};
               my_in    = MOT_W'(0) - {req_y_motion[15], req_y_motion};
               flags_in = req_buttons;
               old_in   = prev_ff;
               prev_in  = req_buttons;
               state_in = TOP_START;
            end
         end
         TOP_CALC: begin
            if (!busy_x && !busy_y) begin
               state_in = TOP_IDLE;
            end
         end
         TOP_START: begin
            state_in = TOP_RUN;
         end
         TOP_RUN: begin
            if (!busy_x && !busy_y) begin
               sx_in    = coord_x;
               sy_in    = coord_y;
               bkind_in = up ? EV_DOWN : EV_UP;
               bsel_in  = btn;
               if (has_move) begin
                  valid_in = 1'b1;
                  kind_in  = EV_MOVE;
                  bnum_in  = BTN_NONE;
                  last_in  = !has_btn;
                  pend_in  = has_btn;
                  state_in = TOP_EMIT;
               end else if (has_btn) begin
                  valid_in = 1'b1;
                  kind_in  = up ? EV_DOWN : EV_UP;
                  bnum_in  = btn;
                  last_in  = 1'b1;
                  pend_in  = 1'b0;
                  state_in = TOP_EMIT;
               end else begin
                  state_in = TOP_IDLE;
               end
            end
         end
         TOP_EMIT: begin
            if (valid_ff && rsp_ready) begin
               if (pend_ff) begin
                  kind_in = bkind_ff;
                  bnum_in = bsel_ff;
                  last_in = 1'b1;
                  pend_in = 1'b0;
               end else begin
                  valid_in = 1'b0;
                  state_in = TOP_IDLE;
               end
            end
         end
         default: begin
            state_in = TOP_IDLE;
         end
      endcase
      if (csr_wr) begin
         case (csr_idx)
            REG_SPEED: begin
               speed_in = csr_pwdata[SPEED_W-1:0];
            end
            REG_WIDTH: begin
               width_in  = csr_pwdata[SIZE_W-1:0];
               recalc_in = 1'b1;
            end
            REG_HEIGHT: begin
               height_in = csr_pwdata[SIZE_W-1:0];
               recalc_in = 1'b1;
            end
            default: begin
               recalc_in = recalc_in;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= TOP_IDLE;
         speed_ff  <= SPEED_W'(1);
         width_ff  <= SIZE_W'(640);
         height_ff <= SIZE_W'(480);
         recalc_ff <= 1'b1;
         prev_ff   <= '0;
         valid_ff  <= 1'b0;
         pend_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         speed_ff  <= speed_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         recalc_ff <= recalc_in;
         prev_ff   <= prev_in;
         valid_ff  <= valid_in;
         pend_ff   <= pend_in;
      end
      old_ff   <= old_in;
      flags_ff <= flags_in;
      mx_ff    <= mx_in;
      my_ff    <= my_in;
      kind_ff  <= kind_in;
      bnum_ff  <= bnum_in;
      last_ff  <= last_in;
      sx_ff    <= sx_in;
      sy_ff    <= sy_in;
      bkind_ff <= bkind_in;
      bsel_ff  <= bsel_in;
   end

   assign rsp_valid         = valid_ff;
   assign rsp_event_kind    = kind_ff;
   assign rsp_screen_x      = sx_ff;
   assign rsp_screen_y      = sy_ff;
   assign rsp_button_number = bnum_ff;
   assign rsp_last          = last_ff;

endmodule
`default_nettype wire
